/* sv/galois_lfsr_word_packer_defines.svh */
// Assertion helpers used by the datapath RTL file.
`ifndef GALOIS_LFSR_WORD_PACKER_DEFINES_SVH
`define GALOIS_LFSR_WORD_PACKER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GLWP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define GLWP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/glwp_pkg.sv */
package glwp_pkg;

  localparam int unsigned STATE_BITS_DEF = 64;

  localparam logic [63:0] POLY_RESET  = 64'd2011;
  localparam logic [62:0] SEED_RESET  = 63'd109;
  localparam logic [6:0]  WBITS_RESET = 7'd14;

  typedef enum logic [1:0] {
    CFG_POLY  = 2'd0,
    CFG_SEED  = 2'd1,
    CFG_WBITS = 2'd2
  } cfg_reg_e;

  // result status, also the halt reason (OK = running)
  typedef enum logic [1:0] {
    CODE_OK    = 2'd0,
    CODE_ERROR = 2'd1,
    CODE_DONE  = 2'd2
  } code_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CHECK = 2'd1,
    ST_PACK  = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic clear;
    logic step;
    logic shift_bit;
    logic load_status;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic slot_free;
    logic emits;
    logic final_bit;
  } sts_t;

  function automatic logic [5:0] degree_of(input logic [63:0] v);
    logic [5:0] d;
    d = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) d = 6'(i);
    end
    return d;
  endfunction

  function automatic logic [62:0] low_mask63(input logic [5:0] d);
    logic [63:0] m;
    m = (64'd1 << d) - 64'd1;
    return m[62:0];
  endfunction

endpackage

/* sv/glwp_ctrl.sv */
module glwp_ctrl
  import glwp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic restart_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.stop) begin
          if (sts_i.slot_free) state_d = ST_IDLE;
        end else begin
          state_d = ST_PACK;
        end
      end
      ST_PACK: begin
        if ((!sts_i.emits || sts_i.slot_free) && sts_i.final_bit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.clear = in_valid_i & restart_i;
      end
      ST_CHECK: begin
        cmd_o.load_status = sts_i.stop & sts_i.slot_free;
        cmd_o.step        = ~sts_i.stop;
      end
      ST_PACK: begin
        cmd_o.shift_bit = ~sts_i.emits | sts_i.slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/glwp_datapath.sv */
`include "galois_lfsr_word_packer_defines.svh"

module glwp_datapath
  import glwp_pkg::*;
#(
  parameter int unsigned STATE_BITS = STATE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [63:0] cfg_wdata_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] word_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam int unsigned CW = $clog2(STATE_BITS + 1);
  localparam int unsigned IW = $clog2(STATE_BITS);

  // configuration, with polynomial degree and mask kept alongside
  logic [63:0] poly_q;
  logic [62:0] seed_q;
  logic [6:0]  wbits_q;
  logic [5:0]  deg_q;
  logic [62:0] mask_q;

  // generator and packer state
  logic [62:0]           shift_q, shift_d;
  logic [62:0]           steps_q, steps_d;
  code_e                 halt_q, halt_d;
  logic [STATE_BITS-1:0] pend_q, pend_d;
  logic [CW-1:0]         pcnt_q, pcnt_d;
  logic [62:0]           bits_q, bits_d;
  logic [5:0]            bcnt_q, bcnt_d;

  logic        out_valid_q;
  logic [63:0] word_q;
  code_e       status_q;
  logic        last_q;

  logic        slot_free;
  logic        bad_cfg, fin, bad_seed, zero_next;
  logic [63:0] mask64, shifted, next_val;
  code_e       chk_code;

  logic [STATE_BITS-1:0] pend_new, wmask;
  logic [CW-1:0]         pcnt_inc;
  logic                  emits, pack_last;

  logic        load_out;
  logic [63:0] word_d;
  code_e       status_d;
  logic        last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q  <= POLY_RESET;
      seed_q  <= SEED_RESET;
      wbits_q <= WBITS_RESET;
      deg_q   <= degree_of(POLY_RESET);
      mask_q  <= low_mask63(degree_of(POLY_RESET));
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_POLY: begin
          poly_q <= cfg_wdata_i;
          deg_q  <= degree_of(cfg_wdata_i);
          mask_q <= low_mask63(degree_of(cfg_wdata_i));
        end
        CFG_SEED:  seed_q  <= cfg_wdata_i[62:0];
        CFG_WBITS: wbits_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // tick checks and next register value
  assign slot_free = ~out_valid_q | out_ready_i;
  assign mask64    = {1'b0, mask_q};
  assign shifted   = {shift_q, 1'b0};
  assign bad_cfg   = (wbits_q == 7'd0) || (wbits_q > 7'(STATE_BITS)) || (deg_q == 6'd0);
  assign fin       = steps_q >= mask_q;
  assign bad_seed  = (seed_q == 63'd0) || ((seed_q & ~mask_q) != 63'd0) ||
                     ((shift_q & ~mask_q) != 63'd0);

  always_comb begin
    if (shift_q == 63'd0) begin
      next_val = {1'b0, seed_q};
    end else if ((shifted & ~mask64) != 64'd0) begin
      next_val = shifted ^ poly_q;
    end else begin
      next_val = shifted;
    end
  end

  assign zero_next = next_val == 64'd0;

  always_comb begin
    if (halt_q != CODE_OK) chk_code = halt_q;
    else if (bad_cfg)      chk_code = CODE_ERROR;
    else if (fin)          chk_code = CODE_DONE;
    else if (bad_seed)     chk_code = CODE_ERROR;
    else if (zero_next)    chk_code = CODE_ERROR;
    else                   chk_code = CODE_OK;
  end

  // one stream bit per cycle into the accumulator, unless a finished word waits
  always_comb begin
    pend_new = pend_q;
    pend_new[pcnt_q[IW-1:0]] = pend_q[pcnt_q[IW-1:0]] | bits_q[0];
    for (int k = 0; k < STATE_BITS; k++) begin
      wmask[k] = 7'(k) < wbits_q;
    end
  end

  assign pcnt_inc  = pcnt_q + CW'(1);
  assign emits     = 7'(pcnt_inc) >= wbits_q;
  assign pack_last = (7'(bcnt_q) - 7'd1) < wbits_q;

  assign sts_o.stop      = chk_code != CODE_OK;
  assign sts_o.slot_free = slot_free;
  assign sts_o.emits     = emits;
  assign sts_o.final_bit = bcnt_q == 6'd1;

  always_comb begin
    shift_d  = shift_q;
    steps_d  = steps_q;
    halt_d   = halt_q;
    pend_d   = pend_q;
    pcnt_d   = pcnt_q;
    bits_d   = bits_q;
    bcnt_d   = bcnt_q;
    load_out = 1'b0;
    word_d   = 64'd0;
    status_d = CODE_OK;
    last_d   = 1'b1;
    if (cmd_i.clear) begin
      shift_d = '0;
      steps_d = '0;
      halt_d  = CODE_OK;
      pend_d  = '0;
      pcnt_d  = '0;
    end
    if (cmd_i.load_status) begin
      halt_d   = chk_code;
      load_out = 1'b1;
      status_d = chk_code;
      if (chk_code == CODE_DONE) begin
        pend_d = '0;
        pcnt_d = '0;
      end
    end
    if (cmd_i.step) begin
      shift_d = next_val[62:0];
      steps_d = steps_q + 63'd1;
      bits_d  = next_val[62:0];
      bcnt_d  = deg_q;
    end
    if (cmd_i.shift_bit) begin
      bits_d = bits_q >> 1;
      bcnt_d = bcnt_q - 6'd1;
      if (emits) begin
        pend_d   = '0;
        pcnt_d   = '0;
        load_out = 1'b1;
        word_d   = 64'(pend_new & wmask);
        last_d   = pack_last;
      end else begin
        pend_d = pend_new;
        pcnt_d = pcnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      steps_q     <= '0;
      halt_q      <= CODE_OK;
      pend_q      <= '0;
      pcnt_q      <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      shift_q <= shift_d;
      steps_q <= steps_d;
      halt_q  <= halt_d;
      pend_q  <= pend_d;
      pcnt_q  <= pcnt_d;
      bcnt_q  <= bcnt_d;
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    if (load_out) begin
      word_q   <= word_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_o      = word_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  `GLWP_ASSERT_NOW(a_pcnt_range, 1'b1, pcnt_q < CW'(STATE_BITS), "pending count overran")
  `GLWP_ASSERT_NOW(a_pack_running, cmd_i.shift_bit, (bcnt_q != 6'd0) && (halt_q == CODE_OK), "bit packed with none left or while halted")
  `GLWP_ASSERT_NOW(a_no_overwrite, load_out, slot_free, "output register overwritten")
  `GLWP_ASSERT_NEXT(a_status_shape, cmd_i.load_status, (word_q == 64'd0) && last_q && (status_q != CODE_OK), "status result malformed")

endmodule

/* sv/galois_lfsr_word_packer.sv */
// Galois LFSR word packer. Each request that the check does not halt steps
// an LFSR whose modulus is the polynomial register (degree d = highest set
// bit) and packs the d new state bits, LSB first, into words of word_bits
// bits; a request gives zero or more data words, the last of them flagged, or
// one status result (error or finished) flagged last. A stepping request is
// accepted, checked while the register steps, then the bit-serial packer adds
// one bit per cycle unless a finished word waits; a status request is accepted
// and then checked. Results leave through a single output register; a bit that
// completes a word, and a status result, wait while that register holds a
// result that has not been taken. The next request is accepted while a result
// still waits. Write configuration only while the block is idle.
module galois_lfsr_word_packer
  import glwp_pkg::*;
#(
  parameter int unsigned STATE_BITS = STATE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] word_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  cmd_t cmd;
  sts_t sts;

  glwp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  glwp_datapath #(
    .STATE_BITS (STATE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_o      (word_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
